// ===== sv/bgc_pkg.sv =====
// Shared types and constants of the button gesture classifier.
package bgc_pkg;

	// Configuration register width and register map
	localparam int CFG_W = 10;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_HOLD  = 2'd1,
		REG_VLONG_XTRA = 2'd2,
		REG_DBL_WINDOW = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce;
		logic [CFG_W-1:0] long_hold;
		logic [CFG_W-1:0] vlong_extra;
		logic [CFG_W-1:0] dbl_window;
	} cfg_t;

	localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 10'd3;
	localparam logic [CFG_W-1:0] RST_LONG_HOLD  = 10'd50;
	localparam logic [CFG_W-1:0] RST_VLONG_XTRA = 10'd300;
	localparam logic [CFG_W-1:0] RST_DBL_WINDOW = 10'd50;

	// Per-button hold phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_UNDER = 2'd1,
		PH_LONG  = 2'd2,
		PH_VLONG = 2'd3
	} phase_t;

	// Gesture codes on the result port
	localparam int GEST_W = 3;
	typedef enum logic [GEST_W-1:0] {
		G_SHORT      = 3'd0,
		G_DOUBLE     = 3'd1,
		G_LONG_HOLD  = 3'd2,
		G_LONG_REL   = 3'd3,
		G_VLONG_HOLD = 3'd4,
		G_VLONG_REL  = 3'd5
	} gesture_t;

	// At most this many events leave per tick
	localparam int MAX_EVENTS = 6;
	localparam int EM_W = 3;

	// Event queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

endpackage

// ===== sv/bgc_regs.sv =====
// Configuration register file behind the APB-style port.
module bgc_regs
	import bgc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce    <= RST_DEBOUNCE;
			cfg_q.long_hold   <= RST_LONG_HOLD;
			cfg_q.vlong_extra <= RST_VLONG_XTRA;
			cfg_q.dbl_window  <= RST_DBL_WINDOW;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE:   cfg_q.debounce    <= pwdata[CFG_W-1:0];
				REG_LONG_HOLD:  cfg_q.long_hold   <= pwdata[CFG_W-1:0];
				REG_VLONG_XTRA: cfg_q.vlong_extra <= pwdata[CFG_W-1:0];
				REG_DBL_WINDOW: cfg_q.dbl_window  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (idx)
			REG_DEBOUNCE:   prdata = DATA_W'(cfg_q.debounce);
			REG_LONG_HOLD:  prdata = DATA_W'(cfg_q.long_hold);
			REG_VLONG_XTRA: prdata = DATA_W'(cfg_q.vlong_extra);
			REG_DBL_WINDOW: prdata = DATA_W'(cfg_q.dbl_window);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== sv/bgc_front.sv =====
// Front end: takes one pin sample per tick, runs debounce and the per-button timers,
// and classifies the tick's events into slots.
module bgc_front
	import bgc_pkg::*;
#(
	parameter int NUM_BUTTONS = 3,
	parameter int COUNT_BITS  = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfg_t                              cfg,
	input  logic                              pin_valid,
	output logic                              pin_stall,
	input  logic [NUM_BUTTONS-1:0]            pin_levels,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [3*NUM_BUTTONS-1:0]          slot_vld,
	output logic [3*NUM_BUTTONS-1:0][GEST_W-1:0] slot_code
);

	localparam int NB = NUM_BUTTONS;
	localparam int CW = COUNT_BITS;

	logic [NB-1:0] prev_q, snap_q, deb_q;
	logic [CW-1:0] dcnt_q;
	phase_t        phase_q [NB];
	logic [CW-1:0] hcnt_q  [NB];
	logic [NB-1:0] pend_q;
	logic [CW-1:0] wcnt_q  [NB];

	logic [NB-1:0] snap_n, deb_n, pend_n, hfire, wfire, changed;
	logic [CW-1:0] dcnt_n;
	phase_t        ph_n [NB];
	logic [CW-1:0] hc_n [NB];
	logic [CW-1:0] wc_n [NB];
	logic          pin_edge, eval;
	logic          accept;

	// Countdown load value: a zero register loads one
	function automatic logic [CW-1:0] load_of(input logic [CFG_W-1:0] r);
		logic [CW-1:0] v;
		v = CW'(r);
		return (v == '0) ? CW'(1) : v;
	endfunction

	assign pin_stall = q_full;
	assign accept    = pin_valid & ~q_full;
	assign q_push    = accept & (|slot_vld);
	assign pin_edge  = (pin_levels != prev_q);

	// Next state and events of one tick
	always_comb begin
		snap_n    = snap_q;
		deb_n     = deb_q;
		dcnt_n    = dcnt_q;
		pend_n    = pend_q;
		eval      = 1'b0;
		changed   = '0;
		slot_vld  = '0;
		slot_code = '0;

		// Step down the active per-button countdowns
		for (int b = 0; b < NB; b++) begin
			ph_n[b]  = phase_q[b];
			hc_n[b]  = hcnt_q[b];
			wc_n[b]  = wcnt_q[b];
			hfire[b] = 1'b0;
			wfire[b] = 1'b0;
			if (hcnt_q[b] != '0) begin
				hc_n[b]  = hcnt_q[b] - CW'(1);
				hfire[b] = (hcnt_q[b] == CW'(1));
			end
			if (wcnt_q[b] != '0) begin
				wc_n[b]  = wcnt_q[b] - CW'(1);
				wfire[b] = (wcnt_q[b] == CW'(1));
			end
		end

		// Restart debounce on a pin edge, else count down to evaluation
		if (pin_edge) begin
			snap_n = pin_levels;
			dcnt_n = load_of(cfg.debounce);
		end else if (dcnt_q != '0) begin
			dcnt_n = dcnt_q - CW'(1);
			eval   = (dcnt_q == CW'(1));
		end

		if (eval) begin
			changed = (pin_levels ^ deb_q) & ~(pin_levels ^ snap_q);
			deb_n   = pin_levels;
		end

		// Push or release of each changed button
		for (int b = 0; b < NB; b++) begin
			if (changed[NB-1-b]) begin
				hc_n[b]  = '0;
				hfire[b] = 1'b0;
				if (!pin_levels[NB-1-b]) begin
					ph_n[b] = PH_UNDER;
					hc_n[b] = load_of(cfg.long_hold);
				end else begin
					case (phase_q[b])
						PH_UNDER: begin
							if (!pend_q[b]) begin
								pend_n[b] = 1'b1;
								wc_n[b]   = load_of(cfg.dbl_window);
							end else begin
								pend_n[b]    = 1'b0;
								wc_n[b]      = '0;
								wfire[b]     = 1'b0;
								slot_vld[b]  = 1'b1;
								slot_code[b] = G_DOUBLE;
							end
						end
						PH_LONG: begin
							slot_vld[b]  = 1'b1;
							slot_code[b] = G_LONG_REL;
						end
						PH_VLONG: begin
							slot_vld[b]  = 1'b1;
							slot_code[b] = G_VLONG_REL;
						end
						default: ;
					endcase
					ph_n[b] = PH_IDLE;
				end
			end
		end

		// Hold expiry, then window expiry, per button
		for (int b = 0; b < NB; b++) begin
			if (hfire[b]) begin
				if (ph_n[b] == PH_UNDER) begin
					ph_n[b]               = PH_LONG;
					hc_n[b]               = load_of(cfg.vlong_extra);
					slot_vld[NB+2*b]      = 1'b1;
					slot_code[NB+2*b]     = G_LONG_HOLD;
				end else if (ph_n[b] == PH_LONG) begin
					ph_n[b]               = PH_VLONG;
					slot_vld[NB+2*b]      = 1'b1;
					slot_code[NB+2*b]     = G_VLONG_HOLD;
				end
			end
			if (wfire[b]) begin
				pend_n[b]             = 1'b0;
				ph_n[b]               = PH_IDLE;
				wc_n[b]               = '0;
				slot_vld[NB+2*b+1]    = 1'b1;
				slot_code[NB+2*b+1]   = G_SHORT;
			end
		end
	end

	// Advance the state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '1;
			snap_q <= '1;
			deb_q  <= '1;
			dcnt_q <= '0;
			pend_q <= '0;
			for (int b = 0; b < NB; b++) begin
				phase_q[b] <= PH_IDLE;
				hcnt_q[b]  <= '0;
				wcnt_q[b]  <= '0;
			end
		end else if (accept) begin
			prev_q <= pin_levels;
			snap_q <= snap_n;
			deb_q  <= deb_n;
			dcnt_q <= dcnt_n;
			pend_q <= pend_n;
			for (int b = 0; b < NB; b++) begin
				phase_q[b] <= ph_n[b];
				hcnt_q[b]  <= hc_n[b];
				wcnt_q[b]  <= wc_n[b];
			end
		end
	end

	// A pin edge always leaves the debounce countdown running
	a_edge_arms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pin_edge |=> dcnt_q != '0)
		else $error("debounce countdown idle after a pin edge");

endmodule

// ===== sv/bgc_fifo.sv =====
// Short queue of classified ticks between front and back.
module bgc_fifo
	import bgc_pkg::*;
#(
	parameter int WIDTH = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0]  mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full event queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty event queue");

endmodule

// ===== sv/bgc_back.sv =====
// Back end: drains one queued tick at a time and sends its events one per cycle while event_stall is low.
module bgc_back
	import bgc_pkg::*;
#(
	parameter int NUM_BUTTONS = 3,
	parameter int BTN_W       = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  logic [3*NUM_BUTTONS-1:0]             q_vld,
	input  logic [3*NUM_BUTTONS-1:0][GEST_W-1:0] q_code,
	output logic                                 q_pop,
	output logic                                 event_valid,
	input  logic                                 event_stall,
	output logic [BTN_W-1:0]                     button,
	output logic [GEST_W-1:0]                    gesture,
	output logic                                 last_of_tick
);

	localparam int NB = NUM_BUTTONS;
	localparam int NS = 3 * NUM_BUTTONS;

	logic [NS-1:0]             cur_vld_q;
	logic [NS-1:0][GEST_W-1:0] cur_code_q;
	logic                      busy_q;
	logic [EM_W-1:0]           em_q;
	logic                      out_vld_q;
	logic [BTN_W-1:0]          btn_q;
	gesture_t                  gest_q;
	logic                      last_q;

	logic [NS-1:0]     sel_onehot, rem;
	logic [BTN_W-1:0]  sel_btn;
	logic [GEST_W-1:0] sel_code;
	logic              found, out_free, send, is_last;

	assign event_valid  = out_vld_q;
	assign button       = btn_q;
	assign gesture      = gest_q;
	assign last_of_tick = last_q;

	assign out_free = ~out_vld_q | ~event_stall;
	assign q_pop    = ~busy_q & ~q_empty;
	assign send     = busy_q & out_free;

	// Pick the earliest pending event slot of the current tick
	always_comb begin
		found      = 1'b0;
		sel_onehot = '0;
		sel_btn    = '0;
		sel_code   = '0;
		for (int i = 0; i < NS; i++) begin
			if (cur_vld_q[i] && !found) begin
				found         = 1'b1;
				sel_onehot[i] = 1'b1;
				sel_btn       = (i < NB) ? BTN_W'(i) : BTN_W'((i - NB) >> 1);
				sel_code      = cur_code_q[i];
			end
		end
		rem     = cur_vld_q & ~sel_onehot;
		is_last = (rem == '0) || (em_q == EM_W'(MAX_EVENTS - 1));
	end

	// Load a tick from the queue and step through its events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			em_q      <= '0;
			cur_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q    <= 1'b1;
				em_q      <= '0;
				cur_vld_q <= q_vld;
			end else if (send) begin
				cur_vld_q <= rem;
				if (is_last) begin
					busy_q <= 1'b0;
					em_q   <= '0;
				end else begin
					em_q <= em_q + EM_W'(1);
				end
			end
			if (send) begin
				out_vld_q <= 1'b1;
			end else if (out_free) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Hold the tick payload and the output transaction
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_code_q <= q_code;
		end
		if (send) begin
			btn_q  <= sel_btn;
			gest_q <= gesture_t'(sel_code);
			last_q <= is_last;
		end
	end

	a_em_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> em_q < EM_W'(MAX_EVENTS))
		else $error("too many events sent for one tick");

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cur_vld_q != '0)
		else $error("busy with no pending event slot");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> em_q == '0)
		else $error("event count not cleared between ticks");

endmodule

// ===== sv/button_gesture_classifier.sv =====
// Top level of the button gesture classifier.
// One pin sample (active low, one bit per button, center button on the highest bit) is
// taken per tick on the pin channel; a tick is accepted in every cycle while the
// four-entry event queue has room, so pin_stall rises only when the queue is full.
// The front part does debounce, hold timing and double-click timing for a tick
// and queues the tick's events; the back part sends them on the event channel one
// per cycle while event_stall is low, at most six per tick, the final one flagged by
// last_of_tick, and starts no new event while it loads a tick from the queue. Ticks
// without events never enter the queue. Timer registers are in ticks at byte
// addresses 0, 4, 8 and 12; a register holding zero acts as one.
module button_gesture_classifier
	import bgc_pkg::*;
#(
	parameter int NUM_BUTTONS = 3,
	parameter int COUNT_BITS  = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	input  logic                   pin_valid,
	output logic                   pin_stall,
	input  logic [NUM_BUTTONS-1:0] pin_levels,
	output logic                   event_valid,
	input  logic                   event_stall,
	output logic [((NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1)-1:0] button,
	output logic [GEST_W-1:0]      gesture,
	output logic                   last_of_tick
);

	localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int NS    = 3 * NUM_BUTTONS;
	localparam int QW    = NS * (GEST_W + 1);

	cfg_t                      cfg;
	logic                      q_push, q_pop, q_full, q_empty;
	logic [NS-1:0]             f_vld, b_vld;
	logic [NS-1:0][GEST_W-1:0] f_code, b_code;
	logic [QW-1:0]             q_rdata;

	assign b_vld  = q_rdata[QW-1 -: NS];
	assign b_code = q_rdata[NS*GEST_W-1:0];

	bgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bgc_front #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.COUNT_BITS  (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pin_valid  (pin_valid),
		.pin_stall  (pin_stall),
		.pin_levels (pin_levels),
		.q_full     (q_full),
		.q_push     (q_push),
		.slot_vld   (f_vld),
		.slot_code  (f_code)
	);

	bgc_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_vld, f_code}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	bgc_back #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.BTN_W       (BTN_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_vld        (b_vld),
		.q_code       (b_code),
		.q_pop        (q_pop),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.button       (button),
		.gesture      (gesture),
		.last_of_tick (last_of_tick)
	);

endmodule
